FILE: hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// Segment intersection test package
// Shared 64-bit signed type, saturation limits and saturating arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

    localparam int unsigned W = 64;

    typedef logic signed [W-1:0] t_s64;

    localparam t_s64 S64_MAX = {1'b0, {(W-1){1'b1}}};
    localparam t_s64 S64_MIN = {1'b1, {(W-1){1'b0}}};

    function automatic t_s64 sat_add(input t_s64 a, input t_s64 b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? S64_MIN : S64_MAX;
        end
        return s[W-1:0];
    endfunction

    function automatic t_s64 sat_sub(input t_s64 a, input t_s64 b);
        logic signed [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return s[W] ? S64_MIN : S64_MAX;
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag(input t_s64 v);
        logic [W-1:0] u;
        u = v;
        return u[W-1] ? (~u + W'(1)) : u;
    endfunction

    function automatic t_s64 from_mag(input logic neg, input logic [W-1:0] m);
        if (neg) begin
            return m[W-1] ? S64_MIN : t_s64'(~m + W'(1));
        end
        return m[W-1] ? S64_MAX : t_s64'(m);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/segment_intersection_test_unit.sv
// ----------------------------------------------------------------------------
// Segment intersection test unit
// Tests one pair of fixed-point line segments per request for a crossing.
// ----------------------------------------------------------------------------
// The unit accepts one segment pair in every cycle while o_stall is low and
// returns one result per request, in order. The path runs through two
// restoring dividers in series, one for the slopes and one for the crossing x,
// each with 64 quotient stages, and two four-stage multipliers, also in
// series. A two-entry output buffer lets the pipeline keep moving after the
// consumer stalls until its second entry is filled.
`default_nettype none

module segment_intersection_test_unit
    import sit_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_first_begin_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_begin_y,
    input  logic signed [COORD_WIDTH-1:0] i_first_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_begin_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_begin_y,
    input  logic signed [COORD_WIDTH-1:0] i_second_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_end_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_intersects,
    output logic signed [COORD_WIDTH-1:0] o_cross_x,
    output logic signed [COORD_WIDTH-1:0] o_cross_y
);

    localparam int CW = COORD_WIDTH;
    localparam t_s64 C_MAX = t_s64'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam t_s64 C_MIN = -C_MAX - 64'sd1;

    typedef logic signed [CW-1:0] t_crd;

    typedef struct packed {
        t_crd px, py, qx, qy, rx, ry, sx, sy;
        logic skip;
    } t_seg;

    typedef struct packed {
        t_crd xmin, xmax, ymin, ymax;
    } t_box;

    typedef struct packed {
        t_crd rx, ry, midp, midr;
        t_box box;
        logic skip, pvert, rvert;
    } t_geo;

    typedef struct packed {
        t_crd px, py;
    } t_pc;

    typedef struct packed {
        t_s64 a;
        t_geo g;
    } t_as;

    typedef struct packed {
        t_s64 c;
        t_crd py;
    } t_cs;

    typedef struct packed {
        t_s64 a, b, c, d;
        logic tz;
        t_geo g;
    } t_xs;

    typedef struct packed {
        t_s64 x, icpt;
        logic zero;
        t_box box;
    } t_ys;

    function automatic t_s64 sx64(input t_crd v);
        return t_s64'(v);
    endfunction

    function automatic t_crd smin(input t_crd a, input t_crd b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_crd smax(input t_crd a, input t_crd b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_crd mid2(input t_crd a, input t_crd b);
        logic signed [CW:0] s;
        logic signed [CW:0] h;
        s = {a[CW-1], a} + {b[CW-1], b};
        h = s + {{CW{1'b0}}, s[CW]};
        return h[CW:1];
    endfunction

    function automatic t_crd clip(input t_s64 v);
        t_s64 c;
        c = v;
        if (v > C_MAX) c = C_MAX;
        if (v < C_MIN) c = C_MIN;
        return c[CW-1:0];
    endfunction

    logic w_en;
    assign w_en    = !o_stall;

    // Front stage: shared endpoint check and ordering of the pair.
    logic w_swap;
    t_seg n_f;
    t_seg r_f;
    logic r_f_vld;

    assign w_swap = (i_first_begin_x > i_second_begin_x)
                    || (i_first_begin_x == i_second_begin_x
                        && i_first_begin_y > i_second_begin_y);

    always_comb begin
        n_f.skip = (i_first_begin_x == i_second_begin_x
                    && i_first_begin_y == i_second_begin_y)
                   || (i_first_end_x == i_second_end_x
                       && i_first_end_y == i_second_end_y);
        if (w_swap) begin
            n_f.px = i_second_begin_x;
            n_f.py = i_second_begin_y;
            n_f.qx = i_second_end_x;
            n_f.qy = i_second_end_y;
            n_f.rx = i_first_begin_x;
            n_f.ry = i_first_begin_y;
            n_f.sx = i_first_end_x;
            n_f.sy = i_first_end_y;
        end else begin
            n_f.px = i_first_begin_x;
            n_f.py = i_first_begin_y;
            n_f.qx = i_first_end_x;
            n_f.qy = i_first_end_y;
            n_f.rx = i_second_begin_x;
            n_f.ry = i_second_begin_y;
            n_f.sx = i_second_end_x;
            n_f.sy = i_second_end_y;
        end
    end

    // Setup stage: slope operands, bounding box overlap and midpoints.
    logic signed [CW:0] w_na, w_da, w_nc, w_dc;
    t_geo n_g;
    t_pc  n_pc;
    t_geo r_g;
    t_pc  r_g_pc;
    t_s64 r_g_na, r_g_da, r_g_nc, r_g_dc;
    logic r_g_vld;

    assign w_na = {r_f.ry[CW-1], r_f.ry} - {r_f.sy[CW-1], r_f.sy};
    assign w_da = {r_f.rx[CW-1], r_f.rx} - {r_f.sx[CW-1], r_f.sx};
    assign w_nc = {r_f.py[CW-1], r_f.py} - {r_f.qy[CW-1], r_f.qy};
    assign w_dc = {r_f.px[CW-1], r_f.px} - {r_f.qx[CW-1], r_f.qx};

    always_comb begin
        n_g.rx       = r_f.rx;
        n_g.ry       = r_f.ry;
        n_g.midp     = mid2(r_f.px, r_f.qx);
        n_g.midr     = mid2(r_f.rx, r_f.sx);
        n_g.box.xmin = smax(smin(r_f.px, r_f.qx), smin(r_f.rx, r_f.sx));
        n_g.box.xmax = smin(smax(r_f.px, r_f.qx), smax(r_f.rx, r_f.sx));
        n_g.box.ymin = smax(smin(r_f.py, r_f.qy), smin(r_f.ry, r_f.sy));
        n_g.box.ymax = smin(smax(r_f.py, r_f.qy), smax(r_f.ry, r_f.sy));
        n_g.skip     = r_f.skip;
        n_g.pvert    = (r_f.px == r_f.qx);
        n_g.rvert    = (r_f.rx == r_f.sx);
        n_pc.px      = r_f.px;
        n_pc.py      = r_f.py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= i_valid;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f    <= n_f;
            r_g    <= n_g;
            r_g_pc <= n_pc;
            r_g_na <= t_s64'(w_na);
            r_g_da <= t_s64'(w_da);
            r_g_nc <= t_s64'(w_nc);
            r_g_dc <= t_s64'(w_dc);
        end
    end

    // Slopes of both segments.
    logic w_da_vld, w_dc_vld;
    t_s64 w_a, w_c;
    t_geo w_da_geo;
    t_pc  w_dc_pc;

    sit_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_geo))) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_vld),
        .i_num   (r_g_na),
        .i_den   (r_g_da),
        .i_side  (r_g),
        .o_valid (w_da_vld),
        .o_quo   (w_a),
        .o_side  (w_da_geo)
    );

    sit_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_pc))) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_g_vld),
        .i_num   (r_g_nc),
        .i_den   (r_g_dc),
        .i_side  (r_g_pc),
        .o_valid (w_dc_vld),
        .o_quo   (w_c),
        .o_side  (w_dc_pc)
    );

    // Intercept products.
    t_as  w_as_in, w_as_out;
    t_cs  w_cs_in, w_cs_out;
    t_s64 w_ma, w_mc;
    logic w_ma_vld, w_mc_vld;

    assign w_as_in.a  = w_a;
    assign w_as_in.g  = w_da_geo;
    assign w_cs_in.c  = w_c;
    assign w_cs_in.py = w_dc_pc.py;

    sit_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_as))) u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_da_vld),
        .i_a     (w_a),
        .i_b     (sx64(w_da_geo.rx)),
        .i_side  (w_as_in),
        .o_valid (w_ma_vld),
        .o_prod  (w_ma),
        .o_side  (w_as_out)
    );

    sit_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_cs))) u_mul_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dc_vld),
        .i_a     (w_c),
        .i_b     (sx64(w_dc_pc.px)),
        .i_side  (w_cs_in),
        .o_valid (w_mc_vld),
        .o_prod  (w_mc),
        .o_side  (w_cs_out)
    );

    // Intercepts and slope difference, then the crossing numerator.
    t_s64 r_h_a, r_h_b, r_h_c, r_h_d, r_h_t;
    t_geo r_h_geo;
    logic r_h_vld;
    t_xs  r_i_side;
    t_s64 r_i_e, r_i_t;
    logic r_i_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld <= 1'b0;
            r_i_vld <= 1'b0;
        end else if (w_en) begin
            r_h_vld <= w_ma_vld && w_mc_vld;
            r_i_vld <= r_h_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h_a      <= w_as_out.a;
            r_h_c      <= w_cs_out.c;
            r_h_b      <= sat_sub(sx64(w_as_out.g.ry), w_ma);
            r_h_d      <= sat_sub(sx64(w_cs_out.py), w_mc);
            r_h_t      <= sat_sub(w_as_out.a, w_cs_out.c);
            r_h_geo    <= w_as_out.g;

            r_i_e      <= sat_sub(r_h_d, r_h_b);
            r_i_t      <= r_h_t;
            r_i_side.a <= r_h_a;
            r_i_side.b <= r_h_b;
            r_i_side.c <= r_h_c;
            r_i_side.d <= r_h_d;
            r_i_side.tz <= (r_h_t == '0);
            r_i_side.g <= r_h_geo;
        end
    end

    // Crossing x of the two lines.
    t_s64 w_xq;
    t_xs  w_xs;
    logic w_x_vld;

    sit_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_xs))) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_i_vld),
        .i_num   (r_i_e),
        .i_den   (r_i_t),
        .i_side  (r_i_side),
        .o_valid (w_x_vld),
        .o_quo   (w_xq),
        .o_side  (w_xs)
    );

    // Select the crossing x and the line that gives y.
    t_ys  n_j;
    t_s64 n_j_slope;
    t_ys  r_j;
    t_s64 r_j_slope;
    logic r_j_vld;

    always_comb begin
        n_j.box  = w_xs.g.box;
        n_j.zero = w_xs.g.skip || (w_xs.g.rvert && w_xs.g.pvert)
                   || (!w_xs.g.rvert && !w_xs.g.pvert && w_xs.tz);
        if (!w_xs.g.rvert) begin
            n_j_slope = w_xs.a;
            n_j.icpt  = w_xs.b;
            n_j.x     = w_xs.g.pvert ? sx64(w_xs.g.midp) : w_xq;
        end else begin
            n_j_slope = w_xs.c;
            n_j.icpt  = w_xs.d;
            n_j.x     = sx64(w_xs.g.midr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j_vld <= 1'b0;
        end else if (w_en) begin
            r_j_vld <= w_x_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j       <= n_j;
            r_j_slope <= n_j_slope;
        end
    end

    // Crossing y.
    t_s64 w_yp;
    t_ys  w_ys;
    logic w_y_vld;

    sit_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(t_ys))) u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_j_vld),
        .i_a     (r_j_slope),
        .i_b     (r_j.x),
        .i_side  (r_j),
        .o_valid (w_y_vld),
        .o_prod  (w_yp),
        .o_side  (w_ys)
    );

    t_s64 r_k_y;
    t_ys  r_k;
    logic r_k_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else if (w_en) begin
            r_k_vld <= w_y_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_k_y <= sat_add(w_yp, w_ys.icpt);
            r_k   <= w_ys;
        end
    end

    // Box test, output clipping and the output buffer.
    logic w_hit;
    t_crd w_cx, w_cy;
    logic r_skid_vld;
    logic r_skid_hit;
    t_crd r_skid_x, r_skid_y;

    assign w_hit = !r_k.zero
                   && (sx64(r_k.box.xmin) < r_k.x) && (r_k.x < sx64(r_k.box.xmax))
                   && (sx64(r_k.box.ymin) < r_k_y) && (r_k_y < sx64(r_k.box.ymax));
    assign w_cx  = r_k.zero ? '0 : clip(r_k.x);
    assign w_cy  = r_k.zero ? '0 : clip(r_k_y);

    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid    <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!o_valid || !i_stall) begin
            if (r_skid_vld) begin
                o_valid    <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                o_valid    <= r_k_vld;
            end
        end else if (r_k_vld && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_valid || !i_stall) begin
            if (r_skid_vld) begin
                o_intersects <= r_skid_hit;
                o_cross_x    <= r_skid_x;
                o_cross_y    <= r_skid_y;
            end else begin
                o_intersects <= w_hit;
                o_cross_x    <= w_cx;
                o_cross_y    <= w_cy;
            end
        end else if (!r_skid_vld) begin
            r_skid_hit <= w_hit;
            r_skid_x   <= w_cx;
            r_skid_y   <= w_cy;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sit_divq.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Computes (num * 2^FRAC_BITS) / den truncated toward zero with saturation,
// one restoring quotient bit per stage, with a side payload carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_divq
    import sit_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_s64              i_num,
    input  t_s64              i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_s64              o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic [2*W-1:0] w_wide;
    logic [W-1:0]   w_den_mag;

    logic              r_vld  [0:W];
    logic [W-1:0]      r_rem  [0:W-1];
    logic [W-1:0]      r_lo   [0:W-1];
    logic [W-1:0]      r_den  [0:W-1];
    logic [W-1:0]      r_quo  [0:W];
    logic              r_neg  [0:W];
    logic              r_sat  [0:W];
    logic [SIDE_W-1:0] r_side [0:W];

    assign w_wide    = {W'(0), mag(i_num)} << FRAC_BITS;
    assign w_den_mag = mag(i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_wide[2*W-1:W];
            r_lo[0]   <= w_wide[W-1:0];
            r_den[0]  <= w_den_mag;
            r_quo[0]  <= '0;
            r_neg[0]  <= i_num[W-1] ^ i_den[W-1];
            r_sat[0]  <= (w_wide[2*W-1:W] >= w_den_mag);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_step
        logic [W:0]   w_try;
        logic [W+1:0] w_diff;
        logic         w_ge;

        assign w_try  = {r_rem[k], r_lo[k][W-1]};
        assign w_diff = {1'b0, w_try} - {2'b00, r_den[k]};
        assign w_ge   = !w_diff[W+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1]  <= {r_quo[k][W-2:0], w_ge};
                r_neg[k+1]  <= r_neg[k];
                r_sat[k+1]  <= r_sat[k];
                r_side[k+1] <= r_side[k];
            end
        end

        if (k < W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= w_ge ? w_diff[W-1:0] : w_try[W-1:0];
                    r_lo[k+1]  <= {r_lo[k][W-2:0], 1'b0};
                    r_den[k+1] <= r_den[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_vld[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_sat[W]) begin
                o_quo <= r_neg[W] ? S64_MIN : S64_MAX;
            end else begin
                o_quo <= from_mag(r_neg[W], r_quo[W]);
            end
            o_side <= r_side[W];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sit_mulq.sv
// ----------------------------------------------------------------------------
// Pipelined fixed-point multiplier
// Computes (a * b) / 2^FRAC_BITS truncated toward zero with saturation from
// four registered 32x32 partial products, with a side payload carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_mulq
    import sit_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int SIDE_W    = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_s64              i_a,
    input  t_s64              i_b,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output t_s64              o_prod,
    output logic [SIDE_W-1:0] o_side
);

    localparam int unsigned H = W / 2;

    logic              r_vld  [1:3];
    logic              r_neg  [1:3];
    logic [SIDE_W-1:0] r_side [1:3];

    logic [W-1:0]   r_x;
    logic [W-1:0]   r_y;
    logic [W-1:0]   r_ll;
    logic [W-1:0]   r_lh;
    logic [W-1:0]   r_hl;
    logic [W-1:0]   r_hh;
    logic [2*W-1:0] r_prod;
    logic           w_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[1] <= 1'b0;
            r_vld[2] <= 1'b0;
            r_vld[3] <= 1'b0;
            o_valid  <= 1'b0;
        end else if (i_en) begin
            r_vld[1] <= i_valid;
            r_vld[2] <= r_vld[1];
            r_vld[3] <= r_vld[2];
            o_valid  <= r_vld[3];
        end
    end

    assign w_ovf = |r_prod[2*W-1:W+FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x       <= mag(i_a);
            r_y       <= mag(i_b);
            r_neg[1]  <= i_a[W-1] ^ i_b[W-1];
            r_side[1] <= i_side;

            r_ll      <= r_x[H-1:0] * r_y[H-1:0];
            r_lh      <= r_x[H-1:0] * r_y[W-1:H];
            r_hl      <= r_x[W-1:H] * r_y[H-1:0];
            r_hh      <= r_x[W-1:H] * r_y[W-1:H];
            r_neg[2]  <= r_neg[1];
            r_side[2] <= r_side[1];

            r_prod    <= {W'(0), r_ll} + {H'(0), r_lh, H'(0)}
                         + {H'(0), r_hl, H'(0)} + {r_hh, W'(0)};
            r_neg[3]  <= r_neg[2];
            r_side[3] <= r_side[2];

            if (w_ovf) begin
                o_prod <= r_neg[3] ? S64_MIN : S64_MAX;
            end else begin
                o_prod <= from_mag(r_neg[3], r_prod[W-1+FRAC_BITS:FRAC_BITS]);
            end
            o_side <= r_side[3];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sit_checker.sv
// ----------------------------------------------------------------------------
// Segment intersection test checker
// Port-level checks of the output buffer and result channel behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module sit_checker #(
    parameter int COORD_WIDTH = 32
) (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_stall,
    input wire                          o_valid,
    input wire                          i_stall,
    input wire                          o_intersects,
    input wire signed [COORD_WIDTH-1:0] o_cross_x,
    input wire signed [COORD_WIDTH-1:0] o_cross_y
);

    // The held result must not change while the consumer stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_intersects)
                               && $stable(o_cross_x) && $stable(o_cross_y))
        else $error("stalled result changed");

    // A buffered request implies a held result in front of it.
    a_buf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised without a held result");

    // The buffer only fills while the held result is stalled.
    a_buf_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("stall raised without a consumer stall");

    // The buffer keeps its request while the consumer still stalls.
    a_buf_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && i_stall |=> o_stall)
        else $error("buffered request lost during a stall");

    // Reset empties the result path.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result path not empty after reset");

endmodule

bind segment_intersection_test_unit sit_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_intersects (o_intersects),
    .o_cross_x    (o_cross_x),
    .o_cross_y    (o_cross_y)
);

`default_nettype wire

FILE: verif/segment_intersection_test_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment intersection test unit testbench
// Streams segment pairs through the unit with random gaps and output stalls,
// predicts each crossing result in 64-bit saturating fixed point and checks
// the results in order, field by field.
// ----------------------------------------------------------------------------

module segment_intersection_test_unit_test;

    localparam int CW   = 32;
    localparam int FRAC = 16;

    typedef logic signed [63:0] t_wide;
    typedef logic signed [CW-1:0] t_coord;

    localparam t_wide WIDE_MAX = {1'b0, {63{1'b1}}};
    localparam t_wide WIDE_MIN = {1'b1, {63{1'b0}}};
    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed {
        t_coord ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } t_pair;

    typedef struct packed {
        logic   hit;
        t_coord cx;
        t_coord cy;
    } t_crossing;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_stall = 1'b0;
    t_pair     drv = '0;
    logic      o_stall, o_valid, o_intersects;
    t_coord    o_cross_x, o_cross_y;

    t_crossing expected_crossings[$];
    int        mismatches = 0;
    bit        quiet_output = 1'b0;
    int        stall_left = 0;

    always #5 i_clk = ~i_clk;

    segment_intersection_test_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_first_begin_x(drv.ax0), .i_first_begin_y(drv.ay0),
        .i_first_end_x(drv.ax1), .i_first_end_y(drv.ay1),
        .i_second_begin_x(drv.bx0), .i_second_begin_y(drv.by0),
        .i_second_end_x(drv.bx1), .i_second_end_y(drv.by1),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_intersects(o_intersects), .o_cross_x(o_cross_x), .o_cross_y(o_cross_y)
    );

    function automatic t_wide clamp_mag(input logic neg, input logic [127:0] m);
        if (neg) begin
            return (m >= 128'h8000_0000_0000_0000) ? WIDE_MIN : t_wide'(128'd0 - m);
        end
        return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? WIDE_MAX : t_wide'(m);
    endfunction

    function automatic logic [127:0] abs_wide(input t_wide v);
        logic [63:0] u;
        u = v[63] ? (64'd0 - v) : v;
        return {64'd0, u};
    endfunction

    function automatic t_wide add_clamp(input t_wide a, input t_wide b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? WIDE_MIN : WIDE_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_wide sub_clamp(input t_wide a, input t_wide b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? WIDE_MIN : WIDE_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_wide fixed_mul(input t_wide a, input t_wide b);
        logic [127:0] p;
        p = (abs_wide(a) * abs_wide(b)) >> FRAC;
        return clamp_mag(a[63] ^ b[63], p);
    endfunction

    function automatic t_wide fixed_div(input t_wide n, input t_wide d);
        logic [127:0] q;
        if (d == 0) begin
            return (n[63] ^ d[63]) ? WIDE_MIN : WIDE_MAX;
        end
        q = (abs_wide(n) << FRAC) / abs_wide(d);
        return clamp_mag(n[63] ^ d[63], q);
    endfunction

    function automatic t_coord narrow(input t_wide v);
        if (v > t_wide'(COORD_MAX)) return COORD_MAX;
        if (v < t_wide'(COORD_MIN)) return COORD_MIN;
        return v[CW-1:0];
    endfunction

    function automatic t_wide wmin(input t_wide a, input t_wide b);
        return a < b ? a : b;
    endfunction

    function automatic t_wide wmax(input t_wide a, input t_wide b);
        return a > b ? a : b;
    endfunction

    function automatic t_crossing predict_crossing(input t_pair p);
        t_wide px, py, qx, qy, rx, ry, sx, sy, x, y, a, b, c, d, t;
        t_wide xlo, xhi, ylo, yhi;
        t_crossing r;
        r = '0;
        px = p.ax0; py = p.ay0; qx = p.ax1; qy = p.ay1;
        rx = p.bx0; ry = p.by0; sx = p.bx1; sy = p.by1;
        if ((px == rx && py == ry) || (qx == sx && qy == sy)) return r;
        if (px > rx || (px == rx && py > ry)) begin
            t = px; px = rx; rx = t;
            t = py; py = ry; ry = t;
            t = qx; qx = sx; sx = t;
            t = qy; qy = sy; sy = t;
        end
        if (rx != sx) begin
            a = fixed_div(ry - sy, rx - sx);
            b = sub_clamp(ry, fixed_mul(a, rx));
            if (px != qx) begin
                c = fixed_div(py - qy, px - qx);
                d = sub_clamp(py, fixed_mul(c, px));
                t = sub_clamp(a, c);
                if (t == 0) return r;
                x = fixed_div(sub_clamp(d, b), t);
            end else begin
                x = (px + qx) / 2;
            end
            y = add_clamp(fixed_mul(a, x), b);
        end else begin
            if (px == qx) return r;
            c = fixed_div(py - qy, px - qx);
            d = sub_clamp(py, fixed_mul(c, px));
            x = (rx + sx) / 2;
            y = add_clamp(fixed_mul(c, x), d);
        end
        xlo = wmax(wmin(px, qx), wmin(rx, sx));
        xhi = wmin(wmax(px, qx), wmax(rx, sx));
        ylo = wmax(wmin(py, qy), wmin(ry, sy));
        yhi = wmin(wmax(py, qy), wmax(ry, sy));
        r.hit = (xlo < x && x < xhi && ylo < y && y < yhi);
        r.cx = narrow(x);
        r.cy = narrow(y);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_pair(input t_pair p);
        int gap;
        drv = p;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        expected_crossings.insert(expected_crossings.size(), predict_crossing(p));
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic t_coord small_coord(input int bits);
        return t_coord'($signed($urandom_range(0, (1 << bits) - 1)) - (1 << (bits - 1)));
    endfunction

    function automatic t_pair pack_pair(input t_coord a0, a1, a2, a3, b0, b1, b2, b3);
        t_pair p;
        p = {a0, a1, a2, a3, b0, b1, b2, b3};
        return p;
    endfunction

    // Two segments drawn through a common point, so most of them cross.
    function automatic t_pair crossing_pair(input int bits);
        t_coord cx, cy;
        t_coord d1x, d1y, d2x, d2y;
        t_pair p;
        cx = small_coord(bits); cy = small_coord(bits);
        d1x = $urandom_range(1, 1 << (bits - 2)); d1y = small_coord(bits - 1);
        d2x = $urandom_range(0, 1 << (bits - 2)); d2y = small_coord(bits - 1);
        p = pack_pair(cx - d1x, cy - d1y, cx + d1x + small_coord(4), cy + d1y,
                      cx - d2x, cy - d2y, cx + d2x, cy + d2y + small_coord(4));
        return p;
    endfunction

    task automatic test_directed();
        t_coord one;
        one = t_coord'(1 << FRAC);
        send_pair(pack_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                            COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN));
        send_pair(pack_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                            COORD_MIN, COORD_MIN + 1, COORD_MAX, COORD_MAX));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 0, 4 * one, 4 * one, 0));
        send_pair(pack_pair(0, 4 * one, 4 * one, 0, 0, 0, 4 * one, 4 * one));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, one, 0, 3 * one, 4 * one));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 0, 4 * one, 5 * one, 0));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 5 * one, 0, 3 * one, 4 * one));
        send_pair(pack_pair(2 * one, -one, 2 * one, 5 * one, 0, 0, 4 * one, 4 * one));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 2 * one, -one, 2 * one, 5 * one));
        send_pair(pack_pair(one, 0, one, 4 * one, 2 * one, 0, 2 * one, 4 * one));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 0, one, 4 * one, 5 * one));
        send_pair(pack_pair(0, 2 * one, 4 * one, 2 * one, 0, 0, 4 * one, 4 * one));
        send_pair(pack_pair(4 * one, 4 * one, 0, 0, 4 * one, 0, 0, 4 * one));
        send_pair(pack_pair(0, 3 * one, 4 * one, 0, 0, -one, 4 * one, 4 * one));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 0, 0, 4 * one, 0));
        send_pair(pack_pair(0, 0, 4 * one, 4 * one, 0, 4 * one, 4 * one, 4 * one));
        send_pair(pack_pair(0, 0, 1, COORD_MAX, 0, COORD_MAX, 1, 0));
        send_pair(pack_pair(COORD_MIN, 0, COORD_MIN + 1, COORD_MAX,
                            COORD_MAX - 1, COORD_MIN, COORD_MAX, COORD_MAX));
        send_pair(pack_pair(-1, -1, 1, 1, -1, 1, 1, -1));
        send_pair(pack_pair(0, 0, 2 * one, 2 * one, 2 * one, 2 * one, 4 * one, 0));
        send_pair(pack_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                            COORD_MIN, 0, COORD_MAX, 1));
    endtask

    task automatic test_random_pairs(input int count);
        int kind;
        t_pair p;
        t_coord t;
        repeat (count) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                p = crossing_pair($urandom_range(0, 3) == 0 ? 30 : $urandom_range(8, 24));
            end else if (kind < 65) begin
                p = pack_pair($urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
                if ($urandom_range(0, 2) != 0) begin
                    if (p.ax0 > p.ax1) begin t = p.ax0; p.ax0 = p.ax1; p.ax1 = t; end
                    if (p.bx0 > p.bx1) begin t = p.bx0; p.bx0 = p.bx1; p.bx1 = t; end
                end
            end else if (kind < 75) begin
                p = crossing_pair(20);
                if (kind < 70) p.ax1 = p.ax0;
                else p.by1 = p.by0;
                if ($urandom_range(0, 3) == 0) p.bx1 = p.bx0;
            end else if (kind < 85) begin
                p = crossing_pair(20);
                t = small_coord(18);
                p.bx0 = p.ax0 + t; p.bx1 = p.ax1 + t;
                p.by0 = p.ay0 - t; p.by1 = p.ay1 - t;
            end else if (kind < 90) begin
                p = crossing_pair(20);
                if (kind < 88) begin p.bx0 = p.ax0; p.by0 = p.ay0; end
                else begin p.bx1 = p.ax1; p.by1 = p.ay1; end
            end else begin
                p = pack_pair(small_coord(3), small_coord(3), small_coord(3), small_coord(3),
                              small_coord(3), small_coord(3), small_coord(3), small_coord(3));
            end
            send_pair(p);
        end
    endtask

    task automatic test_drain_pause();
        i_valid = 1'b0;
        wait (expected_crossings.size() == 0);
        @(negedge i_clk);
        test_random_pairs(20);
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) quiet_output <= ~quiet_output;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            if (!quiet_output && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_crossings.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result at %0t", $time);
            end else begin
                want = expected_crossings.pop_front();
                if (want.hit !== o_intersects || want.cx !== o_cross_x ||
                    want.cy !== o_cross_y) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch at %0t: expected %0b %0d %0d, got %0b %0d %0d",
                                 $time, want.hit, want.cx, want.cy,
                                 o_intersects, o_cross_x, o_cross_y);
                    end
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("segment_intersection_test_unit_test NOT OK");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_pairs(540);
        test_drain_pause();
        test_random_pairs(540);
        i_valid = 1'b0;
        wait (expected_crossings.size() == 0);
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && expected_crossings.size() == 0) begin
            $display("segment_intersection_test_unit_test OK");
        end else begin
            $display("segment_intersection_test_unit_test NOT OK");
        end
        $finish;
    end

endmodule
